/* design/bir_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types, widths and codes of the bilinear image rescaler.
// ----------------------------------------------------------------------------
package bir_pkg;

  // Default geometry and position precision
  localparam int DefMaxSrcWidth  = 512;
  localparam int DefMaxSrcHeight = 512;
  localparam int DefFracBits     = 16;

  // Register and field widths
  localparam int SizeW  = 10;
  localparam int ScaleW = 12;
  localparam int DstW   = 12;
  localparam int SrcW   = 9;
  localparam int ChanW  = 8;
  localparam int PixW   = 3 * ChanW;
  localparam int DsizeW = SizeW + ScaleW - 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SCALE_X    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SCALE_Y    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MONO_MODE  = 3'd4;

  // Input operation codes
  localparam logic OPER_WRITE   = 1'b0;
  localparam logic OPER_REQUEST = 1'b1;

  // Colour channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [SrcW-1:0]   src_col;
    logic [SrcW-1:0]   src_row;
    logic [ChanW-1:0]  in_red;
    logic [ChanW-1:0]  in_green;
    logic [ChanW-1:0]  in_blue;
    logic [DstW-1:0]   dst_col;
    logic [DstW-1:0]   dst_row;
  } bir_in_t;

  typedef struct packed {
    logic [DstW-1:0]   out_col;
    logic [DstW-1:0]   out_row;
    logic [ChanW-1:0]  out_red;
    logic [ChanW-1:0]  out_green;
    logic [ChanW-1:0]  out_blue;
    logic              out_of_range;
  } bir_out_t;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_SIZE_X,
    DP_SIZE_Y,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_CLAMP,
    DP_READ,
    DP_WEIGHT,
    DP_MAC,
    DP_CHAN,
    DP_OUT
  } bir_op_e;

  typedef struct packed {
    bir_op_e    op;
    logic [1:0] sel;   // neighbour index, or axis for the divider
    logic [1:0] ch;
  } bir_cmd_t;

  typedef struct packed {
    logic oor;
    logic out_free;
    logic mono;
  } bir_status_t;

endpackage

/* design/bir_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_ctrl
// Sequencer of one request: sizes, two divisions, reads, weights, blend.
// ----------------------------------------------------------------------------
module bir_ctrl import bir_pkg::*; #(
  parameter int FRAC_BITS = DefFracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_req_i,
  output logic        in_stall_o,
  input  bir_status_t status_i,
  output bir_cmd_t    cmd_o
);

  localparam int DivSteps = DstW + SizeW + FRAC_BITS;
  localparam int CntW     = $clog2(DivSteps);

  typedef enum logic [3:0] {
    S_IDLE, S_DW, S_DH, S_CHECK, S_DIVX_INIT, S_DIVX, S_DIVY_INIT, S_DIVY,
    S_CLAMP, S_READ, S_WEIGHT, S_MAC, S_CHAN, S_RESULT
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic [1:0]      ch_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o.op  = DP_NOP;
    cmd_o.sel = cnt_q[1:0];
    cmd_o.ch  = ch_q;
    unique case (state_q)
      S_DW:        cmd_o.op = DP_SIZE_X;
      S_DH:        cmd_o.op = DP_SIZE_Y;
      S_DIVX_INIT: begin cmd_o.op = DP_DIV_INIT; cmd_o.sel = 2'd0; end
      S_DIVX:      begin cmd_o.op = DP_DIV_STEP; cmd_o.sel = 2'd0; end
      S_DIVY_INIT: begin cmd_o.op = DP_DIV_INIT; cmd_o.sel = 2'd1; end
      S_DIVY:      begin cmd_o.op = DP_DIV_STEP; cmd_o.sel = 2'd1; end
      S_CLAMP:     cmd_o.op = DP_CLAMP;
      S_READ:      cmd_o.op = DP_READ;
      S_WEIGHT:    cmd_o.op = DP_WEIGHT;
      S_MAC:       cmd_o.op = DP_MAC;
      S_CHAN:      cmd_o.op = DP_CHAN;
      S_RESULT:    cmd_o.op = status_i.out_free ? DP_OUT : DP_NOP;
      default:     cmd_o.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ch_q    <= CH_RED;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_req_i == OPER_REQUEST) state_q <= S_DW;
        end
        S_DW:    state_q <= S_DH;
        S_DH:    state_q <= S_CHECK;
        S_CHECK: state_q <= status_i.oor ? S_RESULT : S_DIVX_INIT;
        S_DIVX_INIT: begin
          cnt_q   <= '0;
          state_q <= S_DIVX;
        end
        S_DIVX: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(DivSteps - 1)) state_q <= S_DIVY_INIT;
        end
        S_DIVY_INIT: begin
          cnt_q   <= '0;
          state_q <= S_DIVY;
        end
        S_DIVY: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(DivSteps - 1)) begin
            cnt_q   <= '0;
            state_q <= S_CLAMP;
          end
        end
        S_CLAMP: state_q <= S_READ;
        S_READ: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[1:0] == 2'd3) begin
            cnt_q   <= '0;
            state_q <= S_WEIGHT;
          end
        end
        S_WEIGHT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[1:0] == 2'd3) begin
            cnt_q   <= '0;
            ch_q    <= CH_RED;
            state_q <= S_MAC;
          end
        end
        S_MAC: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[1:0] == 2'd3) begin
            cnt_q   <= '0;
            state_q <= S_CHAN;
          end
        end
        S_CHAN: begin
          if (status_i.mono || ch_q == CH_BLUE) begin
            state_q <= S_RESULT;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= S_MAC;
          end
        end
        S_RESULT: begin
          if (status_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/bir_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_datapath
// Config registers, frame store, serial divider, blend unit, result register.
// ----------------------------------------------------------------------------
module bir_datapath import bir_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = DefMaxSrcWidth,
  parameter int MAX_SRC_HEIGHT = DefMaxSrcHeight,
  parameter int FRAC_BITS      = DefFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_accept_i,
  input  bir_in_t             in_item_i,
  input  bir_cmd_t            cmd_i,
  output bir_status_t         status_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bir_out_t            out_item_o
);

  localparam int Depth = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AddrW = $clog2(Depth);
  localparam int NumW  = DstW + SizeW + FRAC_BITS;
  localparam int PosW  = SizeW + FRAC_BITS;
  localparam int WgtW  = 2 * FRAC_BITS + 1;
  localparam int AccW  = 2 * FRAC_BITS + ChanW + 1;
  localparam int SumW  = AccW - 2 * FRAC_BITS;
  localparam logic [FRAC_BITS:0] One  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [AccW-1:0]    Half = AccW'(1) << (2 * FRAC_BITS - 1);

  // Configuration
  logic [SizeW-1:0]  src_width_q, src_height_q;
  logic [ScaleW-1:0] scale_x_q, scale_y_q;
  logic              mono_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= SizeW'(512);
      src_height_q <= SizeW'(512);
      scale_x_q    <= ScaleW'(256);
      scale_y_q    <= ScaleW'(256);
      mono_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SRC_WIDTH:  src_width_q  <= cfg_data_i[SizeW-1:0];
        CFG_SRC_HEIGHT: src_height_q <= cfg_data_i[SizeW-1:0];
        CFG_SCALE_X:    scale_x_q    <= cfg_data_i[ScaleW-1:0];
        CFG_SCALE_Y:    scale_y_q    <= cfg_data_i[ScaleW-1:0];
        CFG_MONO_MODE:  mono_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective source size: zero counts as one, clip to the store
  logic [SizeW-1:0] w_eff, h_eff, w_last, h_last;
  always_comb begin
    w_eff = src_width_q;
    if (src_width_q == '0) w_eff = SizeW'(1);
    else if (32'(src_width_q) > MAX_SRC_WIDTH) w_eff = SizeW'(MAX_SRC_WIDTH);
    h_eff = src_height_q;
    if (src_height_q == '0) h_eff = SizeW'(1);
    else if (32'(src_height_q) > MAX_SRC_HEIGHT) h_eff = SizeW'(MAX_SRC_HEIGHT);
    w_last = w_eff - 1'b1;
    h_last = h_eff - 1'b1;
  end

  // Request and destination size
  logic [DstW-1:0]   dc_q, dr_q;
  logic [DsizeW-1:0] dw_q, dh_q;
  logic [SizeW+ScaleW-1:0] size_prod;

  assign size_prod = (cmd_i.op == DP_SIZE_X)
                   ? (SizeW+ScaleW)'(w_eff) * (SizeW+ScaleW)'(scale_x_q)
                   : (SizeW+ScaleW)'(h_eff) * (SizeW+ScaleW)'(scale_y_q);

  always_ff @(posedge clk_i) begin
    if (in_accept_i && in_item_i.operation == OPER_REQUEST) begin
      dc_q <= in_item_i.dst_col;
      dr_q <= in_item_i.dst_row;
    end
    if (cmd_i.op == DP_SIZE_X) dw_q <= size_prod[SizeW+ScaleW-1:8];
    if (cmd_i.op == DP_SIZE_Y) dh_q <= size_prod[SizeW+ScaleW-1:8];
  end

  logic oor;
  assign oor = (DsizeW'(dc_q) >= dw_q) || (DsizeW'(dr_q) >= dh_q);

  // Restoring divider, one quotient bit a cycle; quotient shifts into px/py
  logic [NumW-1:0]   num_q;
  logic [DsizeW-1:0] rem_q;
  logic [PosW-1:0]   px_q, py_q;
  logic [DsizeW-1:0] divisor;
  logic [DsizeW:0]   trial, diff;
  logic              ge;
  logic [DstW+SizeW-1:0] num_prod;

  assign divisor  = cmd_i.sel[0] ? dh_q : dw_q;
  assign num_prod = cmd_i.sel[0]
                  ? (DstW+SizeW)'(dr_q) * (DstW+SizeW)'(h_last)
                  : (DstW+SizeW)'(dc_q) * (DstW+SizeW)'(w_last);
  assign trial    = {rem_q, num_q[NumW-1]};
  assign ge       = trial >= {1'b0, divisor};
  assign diff     = trial - {1'b0, divisor};

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_DIV_INIT) begin
      num_q <= {num_prod, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      if (cmd_i.sel[0]) py_q <= '0;
      else              px_q <= '0;
    end else if (cmd_i.op == DP_DIV_STEP) begin
      num_q <= {num_q[NumW-2:0], 1'b0};
      rem_q <= ge ? diff[DsizeW-1:0] : trial[DsizeW-1:0];
      if (cmd_i.sel[0]) py_q <= {py_q[PosW-2:0], ge};
      else              px_q <= {px_q[PosW-2:0], ge};
    end
  end

  // Clamp neighbours to the frame edge
  logic [SizeW-1:0]     x0_q, x1_q, y0_q, y1_q;
  logic [FRAC_BITS-1:0] tx_q, ty_q;
  logic [SizeW-1:0]     xi, yi, x0, y0;
  logic [SizeW:0]       x0n, y0n;

  always_comb begin
    xi  = px_q[PosW-1:FRAC_BITS];
    yi  = py_q[PosW-1:FRAC_BITS];
    x0  = (xi > w_last) ? w_last : xi;
    y0  = (yi > h_last) ? h_last : yi;
    x0n = {1'b0, x0} + 1'b1;
    y0n = {1'b0, y0} + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_CLAMP) begin
      x0_q <= x0;
      y0_q <= y0;
      x1_q <= (x0n > {1'b0, w_last}) ? w_last : x0n[SizeW-1:0];
      y1_q <= (y0n > {1'b0, h_last}) ? h_last : y0n[SizeW-1:0];
      tx_q <= px_q[FRAC_BITS-1:0];
      ty_q <= py_q[FRAC_BITS-1:0];
    end
  end

  // Frame store: writes on accepted write beats, reads of the four neighbours
  logic [PixW-1:0]  frame_mem [Depth];
  logic [PixW-1:0]  pix_q [4];
  logic             wr_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [SizeW-1:0] rd_x, rd_y;

  assign wr_en   = in_accept_i && in_item_i.operation == OPER_WRITE
                && 32'(in_item_i.src_col) < MAX_SRC_WIDTH
                && 32'(in_item_i.src_row) < MAX_SRC_HEIGHT;
  assign wr_addr = AddrW'(in_item_i.src_row) * AddrW'(MAX_SRC_WIDTH)
                 + AddrW'(in_item_i.src_col);
  assign rd_x    = cmd_i.sel[0] ? x1_q : x0_q;
  assign rd_y    = cmd_i.sel[1] ? y1_q : y0_q;
  assign rd_addr = AddrW'(rd_y) * AddrW'(MAX_SRC_WIDTH) + AddrW'(rd_x);

  always_ff @(posedge clk_i) begin
    if (wr_en) frame_mem[wr_addr] <= {in_item_i.in_red, in_item_i.in_green,
                                      in_item_i.in_blue};
    if (cmd_i.op == DP_READ) pix_q[cmd_i.sel] <= frame_mem[rd_addr];
  end

  // Weights, then one product a cycle into the accumulator
  logic [WgtW-1:0]      wgt_q [4];
  logic [FRAC_BITS:0]   fx, fy;
  logic [WgtW-1:0]      wgt;
  logic [ChanW-1:0]     chan;
  logic [PixW-1:0]      pix_sel;
  logic [AccW-1:0]      prod, acc_q;
  logic [SumW-1:0]      sum;
  logic [ChanW-1:0]     res_sat;
  logic [ChanW-1:0]     red_q, green_q, blue_q;

  assign fx  = cmd_i.sel[0] ? {1'b0, tx_q} : One - {1'b0, tx_q};
  assign fy  = cmd_i.sel[1] ? {1'b0, ty_q} : One - {1'b0, ty_q};
  assign wgt = WgtW'(fx) * WgtW'(fy);

  assign pix_sel = pix_q[cmd_i.sel];
  always_comb begin
    case (cmd_i.ch)
      CH_RED:   chan = pix_sel[3*ChanW-1:2*ChanW];
      CH_GREEN: chan = pix_sel[2*ChanW-1:ChanW];
      default:  chan = pix_sel[ChanW-1:0];
    endcase
  end
  assign prod = AccW'(chan) * AccW'(wgt_q[cmd_i.sel]);

  assign sum     = mono_q ? SumW'((acc_q + Half) >> (2 * FRAC_BITS))
                          : SumW'(acc_q >> (2 * FRAC_BITS));
  assign res_sat = (sum > SumW'(255)) ? 8'hFF : sum[ChanW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_WEIGHT) wgt_q[cmd_i.sel] <= wgt;
    if (cmd_i.op == DP_MAC) acc_q <= ((cmd_i.sel == 2'd0) ? '0 : acc_q) + prod;
    if (cmd_i.op == DP_CHAN) begin
      case (cmd_i.ch)
        CH_RED:   red_q   <= res_sat;
        CH_GREEN: green_q <= res_sat;
        default:  blue_q  <= res_sat;
      endcase
    end
  end

  // Result register
  logic     out_valid_q;
  bir_out_t out_item_q;
  logic     out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == DP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_OUT) begin
      out_item_q.out_col      <= dc_q;
      out_item_q.out_row      <= dr_q;
      out_item_q.out_of_range <= oor;
      out_item_q.out_red      <= oor ? '0 : red_q;
      out_item_q.out_green    <= (oor || mono_q) ? '0 : green_q;
      out_item_q.out_blue     <= (oor || mono_q) ? '0 : blue_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign status_o.oor      = oor;
  assign status_o.out_free = out_free;
  assign status_o.mono     = mono_q;

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == DP_OUT |-> !out_valid_q || !out_stall_i)
    else $error("result register overwritten while held");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == DP_DIV_STEP |-> divisor != '0)
    else $error("divide step with zero destination size");

  a_clamp_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == DP_CLAMP |=> x0_q <= x1_q && x1_q <= w_last
                             && y0_q <= y1_q && y1_q <= h_last)
    else $error("neighbour indices outside the frame");

endmodule

/* design/bilinear_image_rescaler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_rescaler
// Frame store with bilinear resampling of single destination pixels.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_item_i): a write beat stores one
// source pixel and gives no result. A request beat names a destination pixel
// and gives exactly one result beat on the output channel (out_valid_o /
// out_stall_i / out_item_o). Both channels move a beat at an edge where valid
// is high and stall is low.
// A request occupies the block longer in colour mode than in mono mode, most
// of it in the bit-serial divider that forms the two source positions. A
// request that falls outside the destination skips the divisions and blend.
// One item is worked at a time. The result sits in an output register, so a
// stalled receiver holds only the final transfer; the next input beat is taken
// while the previous result waits. A result whose register is still full waits
// in the sequencer.
// Reset restores the default registers and empties the result register; the
// frame store keeps no reset value, so pixels must be written before use.
// Configuration writes take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
module bilinear_image_rescaler import bir_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = DefMaxSrcWidth,
  parameter int MAX_SRC_HEIGHT = DefMaxSrcHeight,
  parameter int FRAC_BITS      = DefFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bir_in_t             in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bir_out_t            out_item_o
);

  bir_cmd_t    cmd;
  bir_status_t status;
  logic        in_accept;

  assign in_accept = in_valid_i && !in_stall_o;

  bir_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_item_i.operation),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bir_datapath #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .FRAC_BITS      (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_accept_i (in_accept),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bilinear image rescaler. Pixel writes and
// destination requests are driven over several register settings, including
// the size and scale extremes. A scoreboard keeps its own copy of the frame
// store and registers, computes the expected resampled pixel for every request
// and compares each result beat field by field. Both channels idle at random
// outside the no_idle phases.
module tb_top;
  import bir_pkg::*;

  localparam int WatchLimit = 20000;
  localparam int DrainCycles = 250;

  class rescale_scoreboard;
    bit [SizeW-1:0]  src_w = 10'd512;
    bit [SizeW-1:0]  src_h = 10'd512;
    bit [ScaleW-1:0] scl_x = 12'd256;
    bit [ScaleW-1:0] scl_y = 12'd256;
    bit              mono  = 1'b0;
    bit [PixW-1:0]   frame_px[int];
    bir_out_t        expected_px[$];
    int              errors = 0;

    function int eff(bit [SizeW-1:0] v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return int'(v);
    endfunction

    function int dst_w();
      return (eff(src_w, DefMaxSrcWidth) * scl_x) >> 8;
    endfunction

    function int dst_h();
      return (eff(src_h, DefMaxSrcHeight) * scl_y) >> 8;
    endfunction

    // Locate the four neighbours and the fractions; return 0 when out of range.
    function bit corners(int dc, int dr, output int xs[2], output int ys[2],
                         output longint unsigned tx, output longint unsigned ty);
      longint unsigned px, py, xi, yi;
      int w, h, dw, dh;
      w = eff(src_w, DefMaxSrcWidth);
      h = eff(src_h, DefMaxSrcHeight);
      dw = dst_w();
      dh = dst_h();
      if (dc >= dw || dr >= dh) return 0;
      px = ((longint'(dc) * (w - 1)) << DefFracBits) / dw;
      py = ((longint'(dr) * (h - 1)) << DefFracBits) / dh;
      tx = px & ((64'd1 << DefFracBits) - 1);
      ty = py & ((64'd1 << DefFracBits) - 1);
      xi = px >> DefFracBits;
      yi = py >> DefFracBits;
      xs[0] = (xi > w - 1) ? w - 1 : int'(xi);
      ys[0] = (yi > h - 1) ? h - 1 : int'(yi);
      xs[1] = (xs[0] + 1 > w - 1) ? w - 1 : xs[0] + 1;
      ys[1] = (ys[0] + 1 > h - 1) ? h - 1 : ys[0] + 1;
      return 1;
    endfunction

    function bit stored(int col, int row);
      return frame_px.exists(row * DefMaxSrcWidth + col);
    endfunction

    function void note_input(bir_in_t it);
      bir_out_t r;
      int xs[2], ys[2];
      longint unsigned tx, ty, one, v, top, bot;
      bit [PixW-1:0] p00, p10, p01, p11;
      if (it.operation == OPER_WRITE) begin
        frame_px[it.src_row * DefMaxSrcWidth + it.src_col] =
          {it.in_red, it.in_green, it.in_blue};
        return;
      end
      r = '0;
      r.out_col = it.dst_col;
      r.out_row = it.dst_row;
      if (!corners(int'(it.dst_col), int'(it.dst_row), xs, ys, tx, ty)) begin
        r.out_of_range = 1'b1;
      end else begin
        one = 64'd1 << DefFracBits;
        p00 = frame_px[ys[0] * DefMaxSrcWidth + xs[0]];
        p10 = frame_px[ys[0] * DefMaxSrcWidth + xs[1]];
        p01 = frame_px[ys[1] * DefMaxSrcWidth + xs[0]];
        p11 = frame_px[ys[1] * DefMaxSrcWidth + xs[1]];
        for (int ch = 0; ch < 3; ch++) begin
          int s;
          s = 16 - 8 * ch;
          top = ((p00 >> s) & 8'hff) * (one - tx) + ((p10 >> s) & 8'hff) * tx;
          bot = ((p01 >> s) & 8'hff) * (one - tx) + ((p11 >> s) & 8'hff) * tx;
          v = top * (one - ty) + bot * ty;
          if (mono) v = v + (64'd1 << (2 * DefFracBits - 1));
          v = v >> (2 * DefFracBits);
          if (v > 255) v = 255;
          if (ch == CH_RED) r.out_red = v[7:0];
          else if (ch == CH_GREEN) r.out_green = v[7:0];
          else r.out_blue = v[7:0];
          if (mono) break;
        end
      end
      expected_px.push_back(r);
    endfunction

    function void check_result(bir_out_t got);
      bir_out_t exp_px;
      if (expected_px.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      exp_px = expected_px.pop_front();
      if (got.out_col !== exp_px.out_col)
        $display("%0t: out_col expected %0d got %0d", $time, exp_px.out_col, got.out_col);
      if (got.out_row !== exp_px.out_row)
        $display("%0t: out_row expected %0d got %0d", $time, exp_px.out_row, got.out_row);
      if (got.out_red !== exp_px.out_red)
        $display("%0t: out_red expected %0d got %0d", $time, exp_px.out_red, got.out_red);
      if (got.out_green !== exp_px.out_green)
        $display("%0t: out_green expected %0d got %0d", $time, exp_px.out_green,
                 got.out_green);
      if (got.out_blue !== exp_px.out_blue)
        $display("%0t: out_blue expected %0d got %0d", $time, exp_px.out_blue, got.out_blue);
      if (got.out_of_range !== exp_px.out_of_range)
        $display("%0t: out_of_range expected %0b got %0b", $time, exp_px.out_of_range,
                 got.out_of_range);
      if (got !== exp_px) errors++;
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  bir_in_t             in_item_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  bir_out_t            out_item_o;

  rescale_scoreboard sb = new();
  bit  no_idle = 1'b0;
  int  stall_left = 0;
  int  quiet_cycles = 0;

  bilinear_image_rescaler uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (no_idle || r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: check accepted beats, then pick the next stall level.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic drive_beat(bir_in_t it);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
  endtask

  task automatic write_px(int col, int row, bit [PixW-1:0] px);
    bir_in_t it;
    it = '0;
    it.operation = OPER_WRITE;
    it.src_col = SrcW'(col);
    it.src_row = SrcW'(row);
    {it.in_red, it.in_green, it.in_blue} = px;
    it.dst_col = DstW'($urandom);
    it.dst_row = DstW'($urandom);
    drive_beat(it);
  endtask

  // Fill any unwritten neighbour first, then send the request.
  task automatic request_px(int dc, int dr);
    bir_in_t it;
    int xs[2], ys[2];
    longint unsigned tx, ty;
    if (sb.corners(dc, dr, xs, ys, tx, ty))
      foreach (xs[i]) foreach (ys[j])
        if (!sb.stored(xs[i], ys[j])) write_px(xs[i], ys[j], PixW'($urandom));
    it = '0;
    {it.in_red, it.in_green, it.in_blue} = PixW'($urandom);
    it.operation = OPER_REQUEST;
    it.src_col = SrcW'($urandom);
    it.src_row = SrcW'($urandom);
    it.dst_col = DstW'(dc);
    it.dst_row = DstW'(dr);
    drive_beat(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_px.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_regs(int w, int h, int sx, int sy, bit m);
    int vals[5];
    vals = '{w, h, sx, sy, int'(m)};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= CfgIdxW'(i);
      cfg_data_i <= CfgDataW'(vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    sb.src_w = SizeW'(w);
    sb.src_h = SizeW'(h);
    sb.scl_x = ScaleW'(sx);
    sb.scl_y = ScaleW'(sy);
    sb.mono = m;
  endtask

  task automatic random_items(int count);
    int dw, dh, w, h;
    for (int n = 0; n < count; n++) begin
      dw = sb.dst_w();
      dh = sb.dst_h();
      w = sb.eff(sb.src_w, DefMaxSrcWidth);
      h = sb.eff(sb.src_h, DefMaxSrcHeight);
      case ($urandom_range(0, 9))
        0: write_px($urandom_range(0, 511), $urandom_range(0, 511), PixW'($urandom));
        1, 2: write_px($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                       PixW'($urandom));
        3: request_px($urandom_range(0, 4095), $urandom_range(0, 4095));
        default:
          if (dw == 0 || dh == 0) request_px($urandom_range(0, 4095), $urandom_range(0, 63));
          else request_px($urandom_range(0, dw - 1), $urandom_range(0, dh - 1));
      endcase
    end
  endtask

  initial begin
    int w, h, sx, sy;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One-pixel source enlarged eight times: edge pixel repeats everywhere.
    set_regs(1, 1, 2048, 2048, 1'b0);
    write_px(0, 0, 24'hff0080);
    write_px(511, 511, 24'h00ff7f);
    write_px(511, 0, 24'hffffff);
    request_px(0, 0);
    request_px(7, 7);
    request_px(8, 0);
    request_px(0, 8);
    request_px(4095, 4095);
    drain();
    // Two by two source, mono rounding, full-range pixels.
    set_regs(2, 2, 640, 384, 1'b1);
    write_px(0, 0, 24'h000000);
    write_px(1, 0, 24'hffffff);
    write_px(0, 1, 24'hff0000);
    write_px(1, 1, 24'h01ffff);
    for (int i = 0; i < 5; i++) request_px(i, i % 3);
    drain();
    // Zero scale: empty destination.
    set_regs(0, 1023, 0, 0, 1'b0);
    request_px(0, 0);
    request_px(2730, 1365);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      no_idle = (ph % 4 == 3);
      case (ph)
        0: set_regs(512, 512, 256, 256, 1'b0);
        1: set_regs(1023, 3, 2048, 2048, 1'b1);
        2: set_regs(5, 0, 2048, 1, 1'b0);
        3: set_regs(512, 512, 2048, 2048, 1'b1);
        default: begin
          w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 24);
          h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 24);
          sx = $urandom_range(0, 2048);
          sy = $urandom_range(0, 2048);
          set_regs(w, h, sx, sy, 1'($urandom_range(0, 1)));
        end
      endcase
      random_items(30);
      drain();
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
